FILE: rtl/core/iorr_pkg.sv
// ----------------------------------------------------------------------------
// iorr_pkg: shared types and constants
// Widths, slot ring depth, sequencer states and the store command bundle.
// ----------------------------------------------------------------------------
package iorr_pkg;

    localparam int DEPTH  = 64;
    localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int TASK_W = 16;
    localparam int WORD_W = 64;

    typedef logic [TASK_W-1:0] t_task;
    typedef logic [WORD_W-1:0] t_word;
    typedef logic [SLOT_W-1:0] t_slot;

    localparam logic [SLOT_W:0] DEPTH_EXT = (SLOT_W + 1)'(DEPTH);
    localparam t_slot           LAST_SLOT = SLOT_W'(DEPTH - 1);
    localparam t_task           DEPTH_TASK = TASK_W'(DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_PLACE,
        S_READ,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic  wr_en;
        t_slot wr_idx;
        t_word wr_data;
        logic  clr_en;
        t_slot clr_idx;
        logic  rd_en;
        t_slot rd_idx;
    } t_store_cmd;

endpackage

FILE: rtl/core/iorr_if.sv
// ----------------------------------------------------------------------------
// iorr_if: channel interfaces
// Result input, release output and total-count configuration channels.
// ----------------------------------------------------------------------------
interface iorr_res_if;
    import iorr_pkg::*;
    logic  valid;
    logic  ready;
    t_task task_number;
    t_word payload_word;

    modport source (output valid, output task_number, output payload_word, input ready);
    modport sink   (input valid, input task_number, input payload_word, output ready);
endinterface

interface iorr_rel_if;
    import iorr_pkg::*;
    logic  valid;
    logic  ready;
    t_task released_task;
    t_word released_word;
    logic  rejected;
    logic  last_of_run;

    modport source (output valid, output released_task, output released_word,
                    output rejected, output last_of_run, input ready);
    modport sink   (input valid, input released_task, input released_word,
                    input rejected, input last_of_run, output ready);
endinterface

interface iorr_cfg_if;
    import iorr_pkg::*;
    logic  valid;
    logic  ready;
    t_task data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/iorr_store.sv
// ----------------------------------------------------------------------------
// iorr_store: slot ring storage
// Data words in a registered-read memory, full flags in flip-flops.
// ----------------------------------------------------------------------------
module iorr_store import iorr_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_store_cmd       i_cmd,
    output logic [DEPTH-1:0] o_full,
    output t_word            o_rd_data
);

    t_word            r_mem [DEPTH];
    logic [DEPTH-1:0] r_full;
    t_word            r_rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= '0;
        end else begin
            if (i_cmd.wr_en) begin
                r_full[i_cmd.wr_idx] <= 1'b1;
            end
            if (i_cmd.clr_en) begin
                r_full[i_cmd.clr_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_cmd.wr_idx] <= i_cmd.wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[i_cmd.rd_idx];
        end
    end

    assign o_full    = r_full;
    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/core/in_order_result_release.sv
// ----------------------------------------------------------------------------
// in_order_result_release: in-order release buffer
// Path: a rejected beat goes through S_CHECK and S_PLACE to the output
//   register; a released run also goes through S_READ and S_EMIT, then one beat
//   per cycle while o_rel is ready. Input is not ready until the run from the
//   head has drained and the sequencer is back in S_IDLE.
// Reset: synchronous; clears full flags, head and total; data memory is not
//   cleared, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module in_order_result_release import iorr_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    iorr_res_if.sink   i_res,
    iorr_cfg_if.sink   i_cfg,
    iorr_rel_if.source o_rel
);

    t_state           r_state, n_state;
    t_task            r_task, n_task;
    t_word            r_word, n_word;
    t_task            r_head, n_head;
    t_slot            r_head_slot, n_head_slot;
    t_task            r_total;
    t_slot            r_off, n_off;
    logic             r_bad, n_bad;
    logic             r_out_valid, n_out_valid;
    t_task            r_out_task, n_out_task;
    t_word            r_out_word, n_out_word;
    logic             r_out_rej, n_out_rej;
    logic             r_out_last, n_out_last;

    t_store_cmd       w_cmd;
    logic [DEPTH-1:0] w_full;
    t_word            w_rd_data;
    logic             w_out_free;
    logic             w_emit;

    iorr_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .o_full    (w_full),
        .o_rd_data (w_rd_data)
    );

    assign w_out_free = !r_out_valid || o_rel.ready;
    assign w_emit     = (r_state == S_EMIT) && w_out_free;

    always_comb begin
        logic [TASK_W:0] diff;
        logic [SLOT_W:0] sum;
        t_slot           slot;
        logic            dup;
        t_task           head_next;
        t_slot           hs_next;
        logic            last;

        diff      = {1'b0, r_task} - {1'b0, r_head};
        sum       = {1'b0, r_head_slot} + {1'b0, r_off};
        slot      = (sum >= DEPTH_EXT) ? SLOT_W'(sum - DEPTH_EXT) : sum[SLOT_W-1:0];
        dup       = !r_bad && w_full[slot];
        head_next = r_head + 1'b1;
        hs_next   = (r_head_slot == LAST_SLOT) ? '0 : r_head_slot + 1'b1;
        last      = !((head_next < r_total) && w_full[hs_next]);

        n_state     = r_state;
        n_task      = r_task;
        n_word      = r_word;
        n_head      = r_head;
        n_head_slot = r_head_slot;
        n_off       = r_off;
        n_bad       = r_bad;
        n_out_valid = r_out_valid && !o_rel.ready;
        n_out_task  = r_out_task;
        n_out_word  = r_out_word;
        n_out_rej   = r_out_rej;
        n_out_last  = r_out_last;
        w_cmd       = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_res.valid) begin
                    n_task  = i_res.task_number;
                    n_word  = i_res.payload_word;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_bad   = diff[TASK_W] || (diff[TASK_W-1:0] >= DEPTH_TASK) ||
                          (r_task >= r_total);
                n_off   = diff[SLOT_W-1:0];
                n_state = S_PLACE;
            end
            S_PLACE: begin
                if (r_bad || dup) begin
                    if (w_out_free) begin
                        n_out_valid = 1'b1;
                        n_out_task  = r_task;
                        n_out_word  = '0;
                        n_out_rej   = 1'b1;
                        n_out_last  = 1'b1;
                        n_state     = S_IDLE;
                    end
                end else begin
                    w_cmd.wr_en   = 1'b1;
                    w_cmd.wr_idx  = slot;
                    w_cmd.wr_data = r_word;
                    n_state       = S_READ;
                end
            end
            S_READ: begin
                if ((r_head < r_total) && w_full[r_head_slot]) begin
                    w_cmd.rd_en  = 1'b1;
                    w_cmd.rd_idx = r_head_slot;
                    n_state      = S_EMIT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out_valid   = 1'b1;
                    n_out_task    = r_head;
                    n_out_word    = w_rd_data;
                    n_out_rej     = 1'b0;
                    n_out_last    = last;
                    w_cmd.clr_en  = 1'b1;
                    w_cmd.clr_idx = r_head_slot;
                    n_head        = head_next;
                    n_head_slot   = hs_next;
                    if (last) begin
                        n_state = S_IDLE;
                    end else begin
                        w_cmd.rd_en  = 1'b1;
                        w_cmd.rd_idx = hs_next;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_head_slot <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_head_slot <= n_head_slot;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid) begin
                r_total <= i_cfg.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_task     <= n_task;
        r_word     <= n_word;
        r_off      <= n_off;
        r_bad      <= n_bad;
        r_out_task <= n_out_task;
        r_out_word <= n_out_word;
        r_out_rej  <= n_out_rej;
        r_out_last <= n_out_last;
    end

    assign i_res.ready         = (r_state == S_IDLE);
    assign i_cfg.ready         = 1'b1;
    assign o_rel.valid         = r_out_valid;
    assign o_rel.released_task = r_out_task;
    assign o_rel.released_word = r_out_word;
    assign o_rel.rejected      = r_out_rej;
    assign o_rel.last_of_run   = r_out_last;

    a_emit_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |-> w_full[r_head_slot])
        else $error("releasing an empty slot");

    a_emit_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |-> (r_head < r_total))
        else $error("release beyond total");

    a_head_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |=> (r_head == $past(r_head) + 1'b1))
        else $error("head did not advance by one");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> ((r_state == S_IDLE) && !r_out_valid))
        else $error("reset did not idle the sequencer");

endmodule

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: in_order_result_release
// Sends task-tagged results out of order and predicts the in-order releases,
// rejects and run-end marks from its own copy of the slot ring, head and
// total. Every release beat is checked field by field against the oldest
// pending prediction. Covers reordering, duplicates, the window edges, the
// total limit (raised, lowered, zero, maximum) and a full-ring release run.
// ----------------------------------------------------------------------------
module testbench;
    import iorr_pkg::*;

    localparam t_task       TOTAL_MAX     = '1;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned RANDOM_ITEMS  = 90;

    typedef enum int unsigned {
        NOISE_ANY,
        NOISE_BELOW,
        NOISE_ABOVE,
        NOISE_REPEAT
    } t_noise;

    typedef struct {
        t_task task_no;
        t_word word;
        logic  rejected;
        logic  last_of_run;
    } t_release;

    logic clk;
    logic rst_n;

    iorr_res_if res_bus ();
    iorr_cfg_if cfg_bus ();
    iorr_rel_if rel_bus ();

    in_order_result_release uut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_res  (res_bus),
        .i_cfg  (cfg_bus),
        .o_rel  (rel_bus)
    );

    // predicted block state
    t_word slot_word [DEPTH];
    bit    slot_held [DEPTH];
    t_task next_release = '0;
    t_task job_total    = '0;

    t_release    pending_releases [$];
    bit          calm;
    int unsigned rel_hold;
    int unsigned errors;
    int unsigned items_sent;
    int unsigned beats_checked;
    int unsigned rejects;
    int unsigned total_writes;
    int unsigned longest_run;

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int unsigned draw_gap();
        return calm ? 0 : $urandom_range(0, 5);
    endfunction

    function automatic t_word random_word();
        return {$urandom, $urandom};
    endfunction

    function automatic void expect_beat(t_task tnum, t_word word, logic rej);
        t_release beat;
        beat.task_no     = tnum;
        beat.word        = word;
        beat.rejected    = rej;
        beat.last_of_run = rej;
        pending_releases.push_back(beat);
    endfunction

    function automatic void predict_release(t_task tnum, t_word word);
        int unsigned tn;
        int unsigned hd;
        int unsigned run;
        t_release    beat;
        tn = tnum;
        hd = next_release;
        if (tn < hd || tn - hd >= DEPTH || tnum >= job_total || slot_held[tn % DEPTH]) begin
            expect_beat(tnum, '0, 1'b1);
            rejects++;
            return;
        end
        slot_word[tn % DEPTH] = word;
        slot_held[tn % DEPTH] = 1'b1;
        run = 0;
        while (run < DEPTH && next_release < job_total && slot_held[next_release % DEPTH]) begin
            expect_beat(next_release, slot_word[next_release % DEPTH], 1'b0);
            slot_held[next_release % DEPTH] = 1'b0;
            next_release++;
            run++;
        end
        if (run > 0) begin
            beat = pending_releases.pop_back();
            beat.last_of_run = 1'b1;
            pending_releases.push_back(beat);
        end
        if (run > longest_run)
            longest_run = run;
    endfunction

    task automatic send_result(input t_task tnum, input t_word word);
        int unsigned gap;
        gap = draw_gap();
        if (gap > 0) begin
            res_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        res_bus.valid        <= 1'b1;
        res_bus.task_number  <= tnum;
        res_bus.payload_word <= word;
        do @(posedge clk); while (!res_bus.ready);
        predict_release(tnum, word);
        items_sent++;
    endtask

    task automatic settle();
        res_bus.valid <= 1'b0;
        do @(posedge clk); while (pending_releases.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_total(input t_task value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.data  <= value;
        do @(posedge clk); while (!cfg_bus.ready);
        job_total = value;
        total_writes++;
        cfg_bus.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_noise(input int unsigned start, input int unsigned n);
        t_noise kind;
        t_task  tnum;
        kind = t_noise'($urandom_range(0, 3));
        case (kind)
            NOISE_ANY: begin
                tnum = t_task'($urandom);
            end
            NOISE_BELOW: begin
                tnum = t_task'(next_release - 1 - $urandom_range(0, 3));
            end
            NOISE_ABOVE: begin
                tnum = t_task'(next_release + DEPTH + $urandom_range(0, 200));
            end
            default: begin
                tnum = t_task'(start + $urandom_range(0, n - 1));
            end
        endcase
        send_result(tnum, random_word());
    endtask

    task automatic check_release();
        t_release want;
        beats_checked++;
        if (pending_releases.size() == 0) begin
            $error("unexpected release beat, task %0d", rel_bus.released_task);
            errors++;
            return;
        end
        want = pending_releases.pop_front();
        if (rel_bus.released_task !== want.task_no) begin
            $error("released_task: expected %0d, got %0d", want.task_no,
                   rel_bus.released_task);
            errors++;
        end
        if (rel_bus.released_word !== want.word) begin
            $error("released_word: expected %h, got %h", want.word, rel_bus.released_word);
            errors++;
        end
        if (rel_bus.rejected !== want.rejected) begin
            $error("rejected: expected %b, got %b", want.rejected, rel_bus.rejected);
            errors++;
        end
        if (rel_bus.last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %b, got %b", want.last_of_run,
                   rel_bus.last_of_run);
            errors++;
        end
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            rel_bus.ready <= 1'b0;
            rel_hold = 0;
        end else if (rel_bus.valid && rel_bus.ready) begin
            check_release();
            rel_hold = draw_gap();
            rel_bus.ready <= (rel_hold == 0);
        end else if (rel_hold > 0) begin
            rel_hold--;
            rel_bus.ready <= (rel_hold == 0);
        end else begin
            rel_bus.ready <= 1'b1;
        end
    end

    // total is zero out of reset: everything is refused
    task automatic test_reset_total();
        send_result('0, '0);
        send_result(TOTAL_MAX, '1);
    endtask

    task automatic test_reorder();
        settle();
        write_total(t_task'(12));
        send_result(t_task'(1), 64'h0123_4567_89ab_cdef);
        send_result(t_task'(0), '1);
        send_result(t_task'(3), 64'h5555_5555_5555_5555);
        send_result(t_task'(3), 64'haaaa_aaaa_aaaa_aaaa);
        send_result(t_task'(1), random_word());
        send_result(t_task'(2), '0);
    endtask

    // run stops at the total with a held slot beyond it
    task automatic test_total_stop();
        send_result(t_task'(6), random_word());
        send_result(t_task'(5), random_word());
        settle();
        write_total(t_task'(6));
        send_result(t_task'(4), random_word());
        send_result(t_task'(7), random_word());
        settle();
        write_total(TOTAL_MAX);
        send_result(t_task'(8), random_word());
        send_result(t_task'(7), random_word());
    endtask

    task automatic test_window_edges();
        send_result(t_task'(next_release + DEPTH), random_word());
        send_result(t_task'(next_release + DEPTH - 1), random_word());
        send_result(TOTAL_MAX, random_word());
        send_result(t_task'(next_release - 1), random_word());
        send_result(next_release, random_word());
    endtask

    task automatic test_total_lowered();
        settle();
        write_total('0);
        send_result(next_release, random_word());
        send_result(TOTAL_MAX, '1);
        settle();
        write_total(TOTAL_MAX);
    endtask

    // shuffled runs from the head with noise and holes; the first run fills
    // the whole ring and sends the head last
    task automatic test_random_runs();
        int unsigned goal;
        int unsigned n;
        int unsigned start;
        int unsigned j;
        int unsigned tmp;
        int unsigned order [$];
        bit          first;
        goal  = items_sent + RANDOM_ITEMS;
        first = 1'b1;
        while (items_sent < goal) begin
            if (first)
                n = DEPTH;
            else if ($urandom_range(0, 7) == 0)
                n = $urandom_range(11, DEPTH);
            else
                n = $urandom_range(1, 10);
            if (!first && $urandom_range(0, 4) == 0) begin
                settle();
                write_total(t_task'(next_release + $urandom_range(0, n)));
            end else if (job_total != TOTAL_MAX) begin
                settle();
                write_total(TOTAL_MAX);
            end
            calm  = !first && ($urandom_range(0, 3) == 0);
            start = next_release;
            order.delete();
            for (int i = 1; i < n; i++)
                order.push_back(i);
            for (int i = int'(order.size()) - 1; i > 0; i--) begin
                j        = $urandom_range(0, i);
                tmp      = order[i];
                order[i] = order[j];
                order[j] = tmp;
            end
            order.insert(first ? order.size() : $urandom_range(0, order.size()), 0);
            foreach (order[k]) begin
                if ($urandom_range(0, 5) == 0)
                    send_noise(start, n);
                if (first || $urandom_range(0, 11) != 0)
                    send_result(t_task'(start + order[k]), random_word());
            end
            first = 1'b0;
        end
        calm = 1'b0;
    endtask

    initial begin
        clk                  = 1'b0;
        rst_n               <= 1'b0;
        res_bus.valid       <= 1'b0;
        res_bus.task_number <= '0;
        res_bus.payload_word <= '0;
        cfg_bus.valid       <= 1'b0;
        cfg_bus.data        <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_total();
        test_reorder();
        test_total_stop();
        test_window_edges();
        test_total_lowered();
        test_random_runs();
        settle();

        $display("%0d result beats in, %0d release beats checked (%0d rejects), %0d total writes",
                 items_sent, beats_checked, rejects, total_writes);
        $display("longest in-order run %0d beats, head ended at task %0d",
                 longest_run, next_release);
        if (errors == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

    initial begin
        #(20 * 300_000);
        $display("timeout with %0d release beats pending", pending_releases.size());
        $display("testbench NOT OK");
        $finish;
    end

endmodule
